// ===== rtl/pspmt_pkg.sv =====
// shared types and constants of the pspmt event classifier
package pspmt_pkg;

    // default parameter values
    localparam int DEF_ENERGY_BITS   = 16;
    localparam int DEF_TIME_BITS     = 48;
    localparam int DEF_POS_FRAC_BITS = 15;

    // fixed field widths
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int Z_BITS        = 12;
    localparam int PIX_BITS      = 7;
    localparam int PIX_QBITS     = 6;

    // register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DYN_LOW_TH  = 3'd0,
        CFG_DYN_HIGH_MIN = 3'd1,
        CFG_DYN_HIGH_MAX = 3'd2,
        CFG_VETO_TH     = 3'd3,
        CFG_ANODE_TH    = 3'd4,
        CFG_ION_Z_TH    = 3'd5,
        CFG_IMPL_Z_TH   = 3'd6
    } cfg_index_t;

    // hit kinds
    typedef enum logic [2:0] {
        HIT_ANODE_HIGH = 3'd0,
        HIT_ANODE_LOW  = 3'd1,
        HIT_DYN_LOW    = 3'd2,
        HIT_DYN_HIGH   = 3'd3,
        HIT_VETO       = 3'd4
    } hit_kind_t;

    // event classes
    typedef enum logic [1:0] {
        EVT_NONE    = 2'd0,
        EVT_IMPLANT = 2'd1,
        EVT_DECAY   = 2'd2,
        EVT_VETO    = 2'd3
    } event_kind_t;

    // request to the divider
    typedef struct packed {
        logic start;
        logic pixel_mode;
    } div_req_t;

endpackage

// ===== rtl/pspmt_event_classify_position.sv =====
// pspmt event classifier with anger-logic position, top level
//
// Usage: detector hits and end-of-event requests enter on the s_ channel.
// A hit (tuser command bit low) is stored and gives no result; a later hit
// of the same kind (and anode tag) replaces an earlier one. An end-of-event
// request classifies the event as none, implant, decay or veto and gives
// exactly one result on the m_ channel, then clears the hit store.
// Order of an end of event: without a position the state goes to ST_FIN,
// which loads the output register, and the next request is taken once it
// is back in ST_IDLE. With a position, 2 ratio divisions and 2 pixel steps
// (multiply-accumulate, then divide) come before the final load for a
// decay; an implant also runs a low-gain correction before each ratio
// division. A single multiply-accumulate unit and one bit-per-cycle
// divider do these steps; hits go at one per cycle while s_tready is high.
// s_tready is low while an end of event is worked on. A finished result
// sits in the output register; hits are still taken while it waits, and
// the next end of event holds in its last step until m_tready takes it.
// Reset (synchronous, aresetn low) loads the register defaults, clears the
// hit store and drops m_tvalid. cfg_we writes register cfg_index.
module pspmt_event_classify_position
    import pspmt_pkg::*;
#(
    parameter int ENERGY_BITS   = DEF_ENERGY_BITS,
    parameter int TIME_BITS     = DEF_TIME_BITS,
    parameter int POS_FRAC_BITS = DEF_POS_FRAC_BITS,
    localparam int IN_BITS  = 2 + ENERGY_BITS + TIME_BITS + 1 + Z_BITS,
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS = 3 + 2 * (POS_FRAC_BITS + 1) + 2 * PIX_BITS + TIME_BITS,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // anode_tag, energy, hit_time, ident_present, nuclear_charge
    input  logic [IN_W-1:0]          s_tdata,
    // command, hit_kind
    input  logic [3:0]               s_tuser,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // implant_with_position, decay_with_position, position_valid, pos_x,
    // pos_y, pixel_x, pixel_y, event_time
    output logic [OUT_W-1:0]         m_tdata,
    // event_kind
    output logic [1:0]               m_tuser,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int EB   = ENERGY_BITS;
    localparam int TB   = TIME_BITS;
    localparam int F    = POS_FRAC_BITS;
    localparam int DIVW = (2 * EB + 16 > F + 14) ? 2 * EB + 16 : F + 14;
    localparam int ACCW = DIVW + 1;
    localparam int BW   = (EB + 1 > 14) ? EB + 1 : 14;
    localparam int CW   = (EB > CFG_DATA_BITS) ? EB : CFG_DATA_BITS;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MAC   = 5'b00010,
        ST_DGO   = 5'b00100,
        ST_DWAIT = 5'b01000,
        ST_FIN   = 5'b10000
    } state_t;

    // input fields
    logic [1:0]        in_tag;
    logic [EB-1:0]     in_energy;
    logic [TB-1:0]     in_time;
    logic              in_ident;
    logic [Z_BITS-1:0] in_z;
    logic              in_cmd;
    logic [2:0]        in_kind;

    assign in_tag    = s_tdata[1:0];
    assign in_energy = s_tdata[2 +: EB];
    assign in_time   = s_tdata[2 + EB +: TB];
    assign in_ident  = s_tdata[2 + EB + TB];
    assign in_z      = s_tdata[3 + EB + TB +: Z_BITS];
    assign in_cmd    = s_tuser[0];
    assign in_kind   = s_tuser[3:1];

    // configuration registers
    logic [CFG_DATA_BITS-1:0] dyn_low_th_reg, dyn_high_min_reg, dyn_high_max_reg;
    logic [CFG_DATA_BITS-1:0] veto_th_reg, anode_th_reg;
    logic [Z_BITS-1:0]        ion_z_th_reg, impl_z_th_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dyn_low_th_reg   <= CFG_DATA_BITS'(5);
            dyn_high_min_reg <= CFG_DATA_BITS'(1);
            dyn_high_max_reg <= CFG_DATA_BITS'(16000);
            veto_th_reg      <= CFG_DATA_BITS'(350);
            anode_th_reg     <= CFG_DATA_BITS'(1);
            ion_z_th_reg     <= Z_BITS'(1);
            impl_z_th_reg    <= Z_BITS'(400);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_DYN_LOW_TH:   dyn_low_th_reg   <= cfg_data;
                CFG_DYN_HIGH_MIN: dyn_high_min_reg <= cfg_data;
                CFG_DYN_HIGH_MAX: dyn_high_max_reg <= cfg_data;
                CFG_VETO_TH:      veto_th_reg      <= cfg_data;
                CFG_ANODE_TH:     anode_th_reg     <= cfg_data;
                CFG_ION_Z_TH:     ion_z_th_reg     <= cfg_data[Z_BITS-1:0];
                CFG_IMPL_Z_TH:    impl_z_th_reg    <= cfg_data[Z_BITS-1:0];
                default: ;
            endcase
        end
    end

    // control and datapath registers
    state_t            state_reg, state_next;
    logic              axis_reg, axis_next;
    logic              pix_reg, pix_next;
    logic [3:0]        ustep_reg, ustep_next;
    logic [EB-1:0]     low_amp_reg [4];
    logic [EB-1:0]     high_amp_reg [4];
    logic              low_seen_reg, high_seen_reg, veto_seen_reg;
    logic [TB-1:0]     low_time_reg, high_time_reg;
    logic [1:0]        kind_reg, kind_next;
    logic              impl_reg, impl_next;
    logic              dec_reg, dec_next;
    logic              posv_reg, posv_next;
    logic              low_mode_reg, low_mode_next;
    logic [TB-1:0]     etime_reg, etime_next;
    logic signed [ACCW-1:0] acc_reg, acc_next;
    logic [2*EB-1:0]   sq0_reg, sq0_next, sq1_reg, sq1_next;
    logic signed [ACCW-1:0] n_reg, n_next, d_reg, d_next;
    logic signed [ACCW-1:0] num_reg, num_next;
    logic [DIVW-1:0]   den_reg, den_next;
    logic signed [F:0] pos_reg [2];
    logic signed [F:0] pos_next [2];
    logic [PIX_BITS-1:0] pxl_reg [2];
    logic [PIX_BITS-1:0] pxl_next [2];
    logic              mv_reg, mv_next;
    logic [OUT_W-1:0]  mdata_reg, mdata_next;
    logic [1:0]        muser_reg, muser_next;

    div_req_t          div_req;
    logic              div_done;
    logic signed [F:0] div_quot;

    logic s_acc, hit_acc, eoe_acc, store_clr;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign hit_acc   = s_acc && !in_cmd;
    assign eoe_acc   = s_acc && in_cmd;

    // hit store
    always_ff @(posedge aclk) begin
        if (!aresetn || store_clr) begin
            for (int i = 0; i < 4; i++) begin
                low_amp_reg[i]  <= '0;
                high_amp_reg[i] <= '0;
            end
            low_seen_reg  <= 1'b0;
            high_seen_reg <= 1'b0;
            veto_seen_reg <= 1'b0;
            low_time_reg  <= '0;
            high_time_reg <= '0;
        end else if (hit_acc) begin
            case (in_kind)
                HIT_ANODE_HIGH: high_amp_reg[in_tag] <= in_energy;
                HIT_ANODE_LOW:  low_amp_reg[in_tag]  <= in_energy;
                HIT_DYN_LOW: begin
                    if (CW'(in_energy) > CW'(dyn_low_th_reg)) begin
                        low_seen_reg <= 1'b1;
                        low_time_reg <= in_time;
                    end
                end
                HIT_DYN_HIGH: begin
                    if (CW'(in_energy) > CW'(dyn_high_min_reg) &&
                        CW'(in_energy) < CW'(dyn_high_max_reg)) begin
                        high_seen_reg <= 1'b1;
                        high_time_reg <= in_time;
                    end
                end
                HIT_VETO: begin
                    if (CW'(in_energy) > CW'(veto_th_reg)) begin
                        veto_seen_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // shared multiply-accumulate unit and sequencer
    always_comb begin
        logic              ion, implant, decay, low_ok, high_ok;
        logic [EB-1:0]     ea, eb;
        logic signed [ACCW-1:0] ea_x, eb_x, sq0_x, sq1_x, op_a;
        logic signed [BW-1:0]   op_b, k1, k2, cn, cd;
        logic signed [ACCW+BW-1:0] prod;
        logic              clr;

        state_next    = state_reg;
        axis_next     = axis_reg;
        pix_next      = pix_reg;
        ustep_next    = ustep_reg;
        kind_next     = kind_reg;
        impl_next     = impl_reg;
        dec_next      = dec_reg;
        posv_next     = posv_reg;
        low_mode_next = low_mode_reg;
        etime_next    = etime_reg;
        acc_next      = acc_reg;
        sq0_next      = sq0_reg;
        sq1_next      = sq1_reg;
        n_next        = n_reg;
        d_next        = d_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        pos_next      = pos_reg;
        pxl_next      = pxl_reg;
        mv_next       = mv_reg && !m_tready;
        mdata_next    = mdata_reg;
        muser_next    = muser_reg;
        store_clr     = 1'b0;
        div_req       = '{start: 1'b0, pixel_mode: pix_reg};

        // classification of the stored event
        ion     = in_ident && (in_z > ion_z_th_reg);
        implant = ion && low_seen_reg && !veto_seen_reg && (in_z > impl_z_th_reg);
        decay   = high_seen_reg && !ion && !veto_seen_reg;
        low_ok  = 1'b1;
        high_ok = 1'b1;
        for (int i = 0; i < 4; i++) begin
            low_ok  = low_ok  && (CW'(low_amp_reg[i])  > CW'(anode_th_reg));
            high_ok = high_ok && (CW'(high_amp_reg[i]) > CW'(anode_th_reg));
        end

        // operand selection for the current axis
        ea    = axis_reg ? low_amp_reg[2] : low_amp_reg[0];
        eb    = axis_reg ? low_amp_reg[3] : low_amp_reg[1];
        ea_x  = {{(ACCW-EB){1'b0}}, ea};
        eb_x  = {{(ACCW-EB){1'b0}}, eb};
        sq0_x = {{(ACCW-2*EB){1'b0}}, sq0_reg};
        sq1_x = {{(ACCW-2*EB){1'b0}}, sq1_reg};
        k1    = axis_reg ? BW'(5000) : BW'(2000);
        k2    = axis_reg ? BW'(3)    : BW'(1);
        cn    = axis_reg ? BW'(850)  : BW'(870);
        cd    = axis_reg ? BW'(-7)   : BW'(14);

        clr  = 1'b1;
        op_a = ea_x;
        op_b = {{(BW-EB){1'b0}}, ea};
        case (ustep_reg)
            4'd0: begin op_a = ea_x; op_b = {{(BW-EB){1'b0}}, ea}; end
            4'd1: begin op_a = eb_x; op_b = {{(BW-EB){1'b0}}, eb}; end
            4'd2: begin op_a = ea_x - eb_x; op_b = k1; end
            4'd3: begin op_a = sq0_x - sq1_x; op_b = k2; clr = 1'b0; end
            4'd4: begin op_a = ea_x + eb_x; op_b = k1; end
            4'd5: begin op_a = sq0_x + sq1_x; op_b = k2; clr = 1'b0; end
            4'd6: begin op_a = n_reg; op_b = cn; end
            4'd7: begin op_a = d_reg; op_b = cd; clr = 1'b0; end
            4'd8: begin op_a = d_reg; op_b = BW'(1000); end
            4'd9: begin
                op_a = {{(ACCW-F-1){pos_reg[axis_reg][F]}}, pos_reg[axis_reg]};
                op_b = BW'(3996);
            end
            4'd10: begin op_a = ACCW'(1200) <<< F; op_b = BW'(1); clr = 1'b0; end
            default: ;
        endcase
        prod = op_a * op_b;

        case (state_reg)
            ST_IDLE: begin
                if (eoe_acc) begin
                    kind_next     = veto_seen_reg ? EVT_VETO :
                                    decay         ? EVT_DECAY :
                                    implant       ? EVT_IMPLANT : EVT_NONE;
                    etime_next    = veto_seen_reg ? '0 :
                                    decay         ? high_time_reg :
                                    implant       ? low_time_reg : '0;
                    impl_next     = implant && low_ok;
                    dec_next      = decay && !(implant && low_ok) && high_ok;
                    posv_next     = (implant && low_ok) || (decay && high_ok);
                    low_mode_next = implant && low_ok;
                    axis_next     = 1'b0;
                    pix_next      = 1'b0;
                    ustep_next    = 4'd0;
                    if (implant && low_ok) begin
                        state_next = ST_MAC;
                    end else if (decay && high_ok) begin
                        num_next   = $signed({1'b0, high_amp_reg[0] - DIVW'(0)}) -
                                     $signed({1'b0, {{(DIVW-EB){1'b0}}, high_amp_reg[1]}});
                        den_next   = {{(DIVW-EB){1'b0}}, high_amp_reg[0]} +
                                     {{(DIVW-EB){1'b0}}, high_amp_reg[1]};
                        state_next = ST_DGO;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_MAC: begin
                acc_next   = (clr ? ACCW'(0) : acc_reg) + prod[ACCW-1:0];
                ustep_next = ustep_reg + 4'd1;
                case (ustep_reg)
                    4'd0: sq0_next = acc_next[2*EB-1:0];
                    4'd1: sq1_next = acc_next[2*EB-1:0];
                    4'd3: n_next   = acc_next;
                    4'd5: d_next   = acc_next;
                    4'd7: num_next = acc_next;
                    4'd8: begin
                        den_next   = acc_next[DIVW-1:0];
                        state_next = ST_DGO;
                    end
                    4'd10: begin
                        num_next   = acc_next;
                        den_next   = DIVW'(100) << (F + PIX_QBITS);
                        state_next = ST_DGO;
                    end
                    default: ;
                endcase
            end
            ST_DGO: begin
                div_req.start = 1'b1;
                state_next    = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (div_done) begin
                    if (!pix_reg) begin
                        pos_next[axis_reg] = div_quot;
                        if (!axis_reg) begin
                            axis_next = 1'b1;
                            if (low_mode_reg) begin
                                ustep_next = 4'd0;
                                state_next = ST_MAC;
                            end else begin
                                num_next   = $signed({1'b0, {{(DIVW-EB){1'b0}}, high_amp_reg[2]}}) -
                                             $signed({1'b0, {{(DIVW-EB){1'b0}}, high_amp_reg[3]}});
                                den_next   = {{(DIVW-EB){1'b0}}, high_amp_reg[2]} +
                                             {{(DIVW-EB){1'b0}}, high_amp_reg[3]};
                                state_next = ST_DGO;
                            end
                        end else begin
                            axis_next  = 1'b0;
                            pix_next   = 1'b1;
                            ustep_next = 4'd9;
                            state_next = ST_MAC;
                        end
                    end else begin
                        pxl_next[axis_reg] = div_quot[PIX_BITS-1:0];
                        if (!axis_reg) begin
                            axis_next  = 1'b1;
                            ustep_next = 4'd9;
                            state_next = ST_MAC;
                        end else begin
                            state_next = ST_FIN;
                        end
                    end
                end
            end
            ST_FIN: begin
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    muser_next = kind_reg;
                    mdata_next = OUT_W'({
                        etime_reg,
                        posv_reg ? pxl_reg[1] : PIX_BITS'(0),
                        posv_reg ? pxl_reg[0] : PIX_BITS'(0),
                        posv_reg ? pos_reg[1] : (F+1)'(0),
                        posv_reg ? pos_reg[0] : (F+1)'(0),
                        posv_reg, dec_reg, impl_reg});
                    store_clr  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
        axis_reg     <= axis_next;
        pix_reg      <= pix_next;
        ustep_reg    <= ustep_next;
        kind_reg     <= kind_next;
        impl_reg     <= impl_next;
        dec_reg      <= dec_next;
        posv_reg     <= posv_next;
        low_mode_reg <= low_mode_next;
        etime_reg    <= etime_next;
        acc_reg      <= acc_next;
        sq0_reg      <= sq0_next;
        sq1_reg      <= sq1_next;
        n_reg        <= n_next;
        d_reg        <= d_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        pos_reg      <= pos_next;
        pxl_reg      <= pxl_next;
        mdata_reg    <= mdata_next;
        muser_reg    <= muser_next;
    end

    // divider
    pspmt_div #(
        .POS_FRAC_BITS (F),
        .DIVW          (DIVW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .num     (num_reg),
        .den     (den_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

endmodule

// ===== rtl/pspmt_div.sv =====
// iterative restoring divider for position ratio and pixel scaling
module pspmt_div
    import pspmt_pkg::*;
#(
    parameter int POS_FRAC_BITS = DEF_POS_FRAC_BITS,
    parameter int DIVW          = 48
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  div_req_t                  req,
    input  logic signed [DIVW:0]      num,
    input  logic        [DIVW-1:0]    den,
    output logic                      done,
    output logic signed [POS_FRAC_BITS:0] quot
);

    localparam int F    = POS_FRAC_BITS;
    localparam int CNTW = $clog2(F + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNTW-1:0]   cnt_reg, cnt_next;
    logic [DIVW:0]     rem_reg, rem_next;
    logic [DIVW-1:0]   den_reg, den_next;
    logic [F:0]        q_reg, q_next;
    logic              neg_reg, neg_next;
    logic              ovf_reg, ovf_next;
    logic              pix_reg, pix_next;

    // one quotient bit per cycle
    always_comb begin
        logic [DIVW:0] mag;
        logic [DIVW:0] r2;
        logic          last;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        neg_next  = neg_reg;
        ovf_next  = ovf_reg;
        pix_next  = pix_reg;
        mag  = num[DIVW] ? (DIVW+1)'(-num) : num;
        r2   = {rem_reg[DIVW-1:0], 1'b0};
        last = pix_reg ? (cnt_reg == CNTW'(PIX_QBITS - 1)) : (cnt_reg == CNTW'(F));
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = mag;
            den_next  = den;
            q_next    = '0;
            neg_next  = num[DIVW];
            ovf_next  = (mag >= {1'b0, den});
            pix_next  = req.pixel_mode;
        end else if (busy_reg) begin
            if (r2 >= {1'b0, den_reg}) begin
                rem_next = r2 - {1'b0, den_reg};
                q_next   = {q_reg[F-1:0], 1'b1};
            end else begin
                rem_next = r2;
                q_next   = {q_reg[F-1:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (last) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
        ovf_reg <= ovf_next;
        pix_reg <= pix_next;
    end

    // rounding and saturation (position mode only) and sign
    always_comb begin
        logic [F+1:0] qr;
        logic [F:0]   lim;
        logic [F:0]   val;
        qr  = ({1'b0, q_reg} + (F+2)'(1)) >> 1;
        lim = neg_reg ? ((F+1)'(1) << F) : (((F+1)'(1) << F) - (F+1)'(1));
        if (pix_reg) begin
            val = q_reg;
        end else if (ovf_reg || (qr[F:0] > lim)) begin
            val = lim;
        end else begin
            val = qr[F:0];
        end
        quot = neg_reg ? $signed(-val) : $signed(val);
    end

    assign done = done_reg;

endmodule
